[src/bed_pkg.sv]
// shared constants for the button event detector
`timescale 1ns / 1ps
`default_nettype none

package bed_pkg;

   // build-time defaults
   localparam int NUM_BUTTONS_DEFAULT = 3;
   localparam int TIME_BITS_DEFAULT   = 48;

   // configuration register indexes and reset values
   localparam int          CSR_ADDR_W           = 1;
   localparam int          CSR_DATA_W           = 24;
   localparam logic [CSR_ADDR_W-1:0] REG_LOCKOUT        = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_HOLD_THRESHOLD = 1'd1;
   localparam logic [23:0] LOCKOUT_RESET        = 24'd200000;
   localparam logic [15:0] HOLD_THRESHOLD_RESET = 16'd1000;

   // action codes of an item
   localparam logic [1:0] ACT_PRESSED  = 2'd0;
   localparam logic [1:0] ACT_RELEASED = 2'd1;
   localparam logic [1:0] ACT_HELD     = 2'd2;

   // microseconds to milliseconds: x / 1000 = (x >> 3) / 125
   // ms saturates once elapsed reaches 1000 * 2^32 us
   localparam int          HOLD_SAT_W   = 42;
   localparam logic [41:0] HOLD_SAT_US  = 42'd4294967296000;
   localparam int          DIV_IN_W     = 39;
   localparam int          DIV_SHIFT    = 46;
   localparam logic [39:0] DIV125_MAGIC = 40'd562949953422;

   // result item width, padded to whole bytes
   localparam int RSP_DATA_W = 40;

endpackage

`default_nettype wire

[src/button_event_detector.sv]
// button press, release and hold detector with per-button state
`timescale 1ns / 1ps
`default_nettype none

// Items pass the input, stage 1, stage 2 and result registers. Throughput: one item
// per cycle unless rsp_tready stalls; the per-button read-modify-write of the
// pressed flag and press time (one subtract and compare) sits in the first stage,
// and the divide by 1000 is a split reciprocal multiply in the two stages after it.
// Reset (synchronous): empties the pipeline, clears every button's flag and press
// time and loads the lockout and hold threshold registers with their defaults.
module button_event_detector #(
   parameter int NUM_BUTTONS = bed_pkg::NUM_BUTTONS_DEFAULT,
   parameter int TIME_BITS   = bed_pkg::TIME_BITS_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // configuration writes
   input  wire                                   csr_we,
   input  wire  [bed_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  wire  [bed_pkg::CSR_DATA_W-1:0]        csr_wdata,
   // poll items
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // button_index[1:0], level, now_us[TIME_BITS-1:0], action[1:0], zero pad
   input  wire  [((TIME_BITS+12)/8)*8-1:0]       req_tdata,
   // result items
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // event_hit, hold_ms[31:0], zero pad
   output logic [bed_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   localparam int EXT_W = (TIME_BITS > bed_pkg::HOLD_SAT_W) ? TIME_BITS : bed_pkg::HOLD_SAT_W;
   localparam int Y_LO  = 20;
   localparam int Y_HI  = bed_pkg::DIV_IN_W - Y_LO;
   localparam int M_LO  = 20;
   localparam int M_HI  = 40 - M_LO;
   localparam int P_W   = 80;
   localparam logic [M_LO-1:0] MAGIC_LO = bed_pkg::DIV125_MAGIC[M_LO-1:0];
   localparam logic [M_HI-1:0] MAGIC_HI = bed_pkg::DIV125_MAGIC[39:M_LO];

   // configuration registers
   logic [23:0] lockout_ff;
   logic [15:0] threshold_ff;

   // per-button state
   logic [NUM_BUTTONS-1:0] press_flag_ff;
   logic [TIME_BITS-1:0]   press_time_ff [NUM_BUTTONS];

   // stage 0: input register
   logic                 s0_valid_ff;
   logic [1:0]           s0_idx_ff;
   logic                 s0_level_ff;
   logic [TIME_BITS-1:0] s0_now_ff;
   logic [1:0]           s0_action_ff;

   // stage 1: state updated, elapsed time ready
   logic                         s1_valid_ff;
   logic                         s1_event_ff;
   logic                         s1_held_chk_ff;
   logic                         s1_pressed_ff;
   logic                         s1_sat_ff;
   logic [bed_pkg::DIV_IN_W-1:0] s1_y_ff;

   // stage 2: partial products of the reciprocal multiply
   logic                 s2_valid_ff;
   logic                 s2_event_ff;
   logic                 s2_held_chk_ff;
   logic                 s2_pressed_ff;
   logic                 s2_sat_ff;
   logic [Y_LO+M_LO-1:0] s2_p_ll_ff;
   logic [Y_LO+M_HI-1:0] s2_p_lh_ff;
   logic [Y_HI+M_LO-1:0] s2_p_hl_ff;
   logic [Y_HI+M_HI-1:0] s2_p_hh_ff;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_event_ff;
   logic [31:0] rsp_hold_ff;

   // stage load enables, bubbles collapse
   logic ld_s0, ld_s1, ld_s2, ld_rsp;

   // stage 0 logic
   logic [NUM_BUTTONS-1:0] hit;
   logic                   in_range;
   logic                   cur_flag;
   logic [TIME_BITS-1:0]   cur_time;
   logic [TIME_BITS-1:0]   elapsed_old;
   logic [TIME_BITS-1:0]   elapsed_hold;
   logic [EXT_W-1:0]       elapsed_ext;
   logic                   do_press;
   logic                   do_release;
   logic                   flag_in;
   logic [TIME_BITS-1:0]   time_in;
   logic                   s1_event_in;
   logic                   s1_held_chk_in;
   logic                   s1_pressed_in;

   // final stage logic
   logic [P_W-1:0] product;
   logic [31:0]    ms;
   logic [31:0]    rsp_hold_in;
   logic           rsp_event_in;

   assign ld_rsp     = !rsp_valid_ff || rsp_tready;
   assign ld_s2      = !s2_valid_ff || ld_rsp;
   assign ld_s1      = !s1_valid_ff || ld_s2;
   assign ld_s0      = !s0_valid_ff || ld_s1;
   assign req_tready = ld_s0;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff   <= bed_pkg::LOCKOUT_RESET;
         threshold_ff <= bed_pkg::HOLD_THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            bed_pkg::REG_LOCKOUT:        lockout_ff   <= csr_wdata[23:0];
            bed_pkg::REG_HOLD_THRESHOLD: threshold_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (ld_s0) begin
         s0_valid_ff <= req_tvalid;
      end
      if (ld_s0) begin
         s0_idx_ff    <= req_tdata[1:0];
         s0_level_ff  <= req_tdata[2];
         s0_now_ff    <= req_tdata[TIME_BITS+2:3];
         s0_action_ff <= req_tdata[TIME_BITS+4:TIME_BITS+3];
      end
   end

   // select the polled button's state
   always_comb begin
      cur_flag = 1'b0;
      cur_time = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         hit[b]   = (32'(s0_idx_ff) == b);
         cur_flag = cur_flag | (hit[b] & press_flag_ff[b]);
         cur_time = cur_time | (hit[b] ? press_time_ff[b] : '0);
      end
      in_range = |hit;
   end

   // press / release decision and elapsed time
   always_comb begin
      elapsed_old  = (s0_now_ff > cur_time) ? (s0_now_ff - cur_time) : '0;
      do_press     = s0_level_ff && !cur_flag
                     && (elapsed_old > TIME_BITS'(lockout_ff));
      do_release   = !s0_level_ff && cur_flag;
      flag_in      = do_press ? 1'b1 : (do_release ? 1'b0 : cur_flag);
      time_in      = do_press ? s0_now_ff : cur_time;
      // a fresh press starts at zero hold time
      elapsed_hold = do_press ? '0 : elapsed_old;
      elapsed_ext  = EXT_W'(elapsed_hold);

      s1_event_in    = in_range && ((do_press && (s0_action_ff == bed_pkg::ACT_PRESSED))
                       || (do_release && (s0_action_ff == bed_pkg::ACT_RELEASED)));
      s1_pressed_in  = in_range && flag_in;
      s1_held_chk_in = s1_pressed_in && (s0_action_ff == bed_pkg::ACT_HELD);
   end

   // per-button state update, once per item leaving stage 0
   always_ff @(posedge clock) begin
      if (reset) begin
         press_flag_ff <= '0;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            press_time_ff[b] <= '0;
         end
      end else if (s0_valid_ff && ld_s1) begin
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (hit[b]) begin
               press_flag_ff[b] <= flag_in;
               press_time_ff[b] <= time_in;
            end
         end
      end
   end

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ld_s1) begin
         s1_valid_ff <= s0_valid_ff;
      end
      if (ld_s1) begin
         s1_event_ff    <= s1_event_in;
         s1_held_chk_ff <= s1_held_chk_in;
         s1_pressed_ff  <= s1_pressed_in;
         s1_sat_ff      <= (elapsed_ext >= EXT_W'(bed_pkg::HOLD_SAT_US));
         s1_y_ff        <= elapsed_ext[bed_pkg::HOLD_SAT_W-1:3];
      end
   end

   // stage 2: partial products of y times the reciprocal of 125
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ld_s2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (ld_s2) begin
         s2_event_ff    <= s1_event_ff;
         s2_held_chk_ff <= s1_held_chk_ff;
         s2_pressed_ff  <= s1_pressed_ff;
         s2_sat_ff      <= s1_sat_ff;
         s2_p_ll_ff     <= (Y_LO+M_LO)'(s1_y_ff[Y_LO-1:0]) * (Y_LO+M_LO)'(MAGIC_LO);
         s2_p_lh_ff     <= (Y_LO+M_HI)'(s1_y_ff[Y_LO-1:0]) * (Y_LO+M_HI)'(MAGIC_HI);
         s2_p_hl_ff     <= (Y_HI+M_LO)'(s1_y_ff[bed_pkg::DIV_IN_W-1:Y_LO])
                           * (Y_HI+M_LO)'(MAGIC_LO);
         s2_p_hh_ff     <= (Y_HI+M_HI)'(s1_y_ff[bed_pkg::DIV_IN_W-1:Y_LO])
                           * (Y_HI+M_HI)'(MAGIC_HI);
      end
   end

   // sum products, saturate and check the hold threshold
   always_comb begin
      product      = P_W'(s2_p_ll_ff)
                     + (P_W'(s2_p_lh_ff) << Y_LO)
                     + (P_W'(s2_p_hl_ff) << M_LO)
                     + (P_W'(s2_p_hh_ff) << (Y_LO + M_LO));
      ms           = s2_sat_ff ? '1 : product[bed_pkg::DIV_SHIFT+31:bed_pkg::DIV_SHIFT];
      rsp_hold_in  = s2_pressed_ff ? ms : '0;
      rsp_event_in = s2_event_ff || (s2_held_chk_ff && (ms > 32'(threshold_ff)));
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ld_rsp) begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (ld_rsp) begin
         rsp_event_ff <= rsp_event_in;
         rsp_hold_ff  <= rsp_hold_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(bed_pkg::RSP_DATA_W-33)'(0), rsp_hold_ff, rsp_event_ff};

   // ready only drops when every stage holds an item
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s0_valid_ff && s1_valid_ff && s2_valid_ff && rsp_valid_ff))
      else $error("input stalled with a bubble in the pipeline");

   // a taken press on a real button sets exactly one more pressed flag
   a_press_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (s0_valid_ff && ld_s1 && do_press && in_range)
      |=> ($countones(press_flag_ff) == $past($countones(press_flag_ff)) + 1))
      else $error("press did not set the button flag");

   // reset leaves no button pressed
   a_reset_clears_flags: assert property (@(posedge clock)
      reset |=> (press_flag_ff == '0))
      else $error("pressed flags not cleared by reset");

   // a hold check is only carried for a pressed button
   a_held_needs_pressed: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_held_chk_ff) |-> s1_pressed_ff)
      else $error("hold check on a released button");

endmodule

`default_nettype wire
